// ===== src/biq_pkg.sv =====
// ----------------------------------------------------------------------------
// Biquad filter package
// Shared constants, register and opcode codes, control word type and the
// microprogram of the biquad sequencer.
// ----------------------------------------------------------------------------
package biq_pkg;

  // Default widths of sample and coefficient words
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned COEF_WIDTH_DEF   = 32;

  // Coefficient register file
  localparam int unsigned NUM_COEFS  = 5;
  localparam int unsigned COEF_IDX_W = 3;

  localparam logic [COEF_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [COEF_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [COEF_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [COEF_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [COEF_IDX_W-1:0] REG_A2 = 3'd4;

  // Accumulator operations
  localparam logic [2:0] ACC_NOP   = 3'd0;  // hold
  localparam logic [2:0] ACC_LD_S1 = 3'd1;  // load scaled first state
  localparam logic [2:0] ACC_LD_S2 = 3'd2;  // load scaled second state plus product
  localparam logic [2:0] ACC_LD_P  = 3'd3;  // load product alone
  localparam logic [2:0] ACC_ADD   = 3'd4;  // add product
  localparam logic [2:0] ACC_SUB   = 3'd5;  // subtract product

  // Round and saturate destinations
  localparam logic [1:0] SAT_NONE = 2'd0;
  localparam logic [1:0] SAT_Y    = 2'd1;
  localparam logic [1:0] SAT_N1   = 2'd2;
  localparam logic [1:0] SAT_N2   = 2'd3;  // also commits states and result

  // Sequencing
  localparam logic [1:0] JMP_NEXT = 2'd0;  // advance
  localparam logic [1:0] JMP_IN   = 2'd1;  // hold until an input word arrives
  localparam logic [1:0] JMP_OUT  = 2'd2;  // hold until output slot free, then home
  localparam logic [1:0] JMP_HOME = 2'd3;  // back to the first step

  // Program steps
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] STEP_B0   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_ACC0 = 4'd2;
  localparam logic [STEP_W-1:0] STEP_Y    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_A1   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SUB1 = 4'd5;
  localparam logic [STEP_W-1:0] STEP_N1   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SUB2 = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DONE = 4'd8;

  typedef struct packed {
    logic [COEF_IDX_W-1:0] coef_sel;
    logic                  mul_en;
    logic                  mul_y;     // multiply by output instead of input
    logic [2:0]            acc_op;
    logic [1:0]            sat_dst;
    logic                  load_in;
    logic [1:0]            jmp;
  } ctl_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  localparam ctl_t CW_NOP = '{coef_sel: REG_B0, mul_en: 1'b0, mul_y: 1'b0,
                              acc_op: ACC_NOP, sat_dst: SAT_NONE, load_in: 1'b0,
                              jmp: JMP_NEXT};

  // Microprogram: one control word per step
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t cw;
    cw = CW_NOP;
    unique case (step)
      STEP_WAIT: begin
        cw.load_in = 1'b1;
        cw.jmp     = JMP_IN;
      end
      STEP_B0: begin
        cw.coef_sel = REG_B0;
        cw.mul_en   = 1'b1;
        cw.acc_op   = ACC_LD_S1;
      end
      STEP_ACC0: begin
        cw.coef_sel = REG_B1;
        cw.mul_en   = 1'b1;
        cw.acc_op   = ACC_ADD;
      end
      STEP_Y: begin
        cw.sat_dst = SAT_Y;
        cw.acc_op  = ACC_LD_S2;
      end
      STEP_A1: begin
        cw.coef_sel = REG_A1;
        cw.mul_en   = 1'b1;
        cw.mul_y    = 1'b1;
      end
      STEP_SUB1: begin
        cw.coef_sel = REG_B2;
        cw.mul_en   = 1'b1;
        cw.acc_op   = ACC_SUB;
      end
      STEP_N1: begin
        cw.sat_dst  = SAT_N1;
        cw.acc_op   = ACC_LD_P;
        cw.coef_sel = REG_A2;
        cw.mul_en   = 1'b1;
        cw.mul_y    = 1'b1;
      end
      STEP_SUB2: begin
        cw.acc_op = ACC_SUB;
      end
      STEP_DONE: begin
        cw.sat_dst = SAT_N2;
        cw.jmp     = JMP_OUT;
      end
      default: begin
        cw.jmp = JMP_HOME;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== src/biq_regs.sv =====
// ----------------------------------------------------------------------------
// Biquad coefficient registers
// APB-style register file holding the five filter coefficients.
// ----------------------------------------------------------------------------
module biq_regs #(
  parameter int unsigned COEF_WIDTH = biq_pkg::COEF_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [((COEF_WIDTH > 32) ? 6 : 5)-1:0]       paddr,
  input  logic [((COEF_WIDTH > 32) ? 64 : 32)-1:0]     pwdata,
  output logic [((COEF_WIDTH > 32) ? 64 : 32)-1:0]     prdata,
  output logic                                         pready,
  output logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs
);

  localparam int unsigned DATA_W = (COEF_WIDTH > 32) ? 64 : 32;
  localparam int unsigned ADDR_W = (COEF_WIDTH > 32) ? 6 : 5;
  localparam int unsigned ALIGN  = (COEF_WIDTH > 32) ? 3 : 2;
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = {2'b01, {(COEF_WIDTH-2){1'b0}}};

  logic [biq_pkg::COEF_IDX_W-1:0] idx;
  logic                           idx_ok;
  logic                           wr_en;

  // Decode word index from byte address
  assign idx    = paddr[ADDR_W-1:ALIGN];
  assign idx_ok = (idx <= biq_pkg::REG_A2);
  assign wr_en  = psel && penable && pwrite && idx_ok;
  assign pready = 1'b1;

  // Write coefficients; b0 comes out of reset at unity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs[biq_pkg::REG_B0] <= COEF_ONE;
      coefs[biq_pkg::REG_B1] <= '0;
      coefs[biq_pkg::REG_B2] <= '0;
      coefs[biq_pkg::REG_A1] <= '0;
      coefs[biq_pkg::REG_A2] <= '0;
    end else if (wr_en) begin
      coefs[idx] <= pwdata[COEF_WIDTH-1:0];
    end
  end

  // Read back the raw register bits
  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = DATA_W'(coefs[idx]);
    end
  end

endmodule

// ===== src/biq_seq.sv =====
// ----------------------------------------------------------------------------
// Biquad sequencer
// Step counter over the microprogram; gates each control word on its
// jump condition and hands it to the datapath.
// ----------------------------------------------------------------------------
module biq_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  biq_pkg::stat_t  stat,
  output biq_pkg::ctl_t   ctl
);

  logic [biq_pkg::STEP_W-1:0] step_r;
  logic [biq_pkg::STEP_W-1:0] step_nxt;
  biq_pkg::ctl_t              cw;
  logic                       go;

  // Fetch the control word of the current step
  assign cw = biq_pkg::ucode(step_r);

  // Evaluate the step's wait condition
  always_comb begin
    unique case (cw.jmp)
      biq_pkg::JMP_IN:  go = in_valid;
      biq_pkg::JMP_OUT: go = stat.out_free;
      default:          go = 1'b1;
    endcase
  end

  assign in_ready = (cw.jmp == biq_pkg::JMP_IN);
  assign ctl      = go ? cw : biq_pkg::CW_NOP;

  // Advance, hold or return home
  always_comb begin
    step_nxt = step_r;
    if (go) begin
      if (cw.jmp == biq_pkg::JMP_OUT || cw.jmp == biq_pkg::JMP_HOME) begin
        step_nxt = biq_pkg::STEP_WAIT;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= biq_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

`ifndef SYNTH
  // Input words are taken only at the first step, and the program moves on
  a_load_at_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_in |-> (step_r == biq_pkg::STEP_WAIT))
    else $error("input word taken outside the wait step");

  a_load_advances: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_in |=> (step_r == biq_pkg::STEP_B0))
    else $error("program did not advance after taking a word");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= biq_pkg::STEP_DONE)
    else $error("step counter left the program");
`endif

endmodule

// ===== src/biq_dpath.sv =====
// ----------------------------------------------------------------------------
// Biquad datapath
// One registered multiplier, one accumulator, round and saturate units,
// filter state and the output word register.
// ----------------------------------------------------------------------------
module biq_dpath #(
  parameter int unsigned SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH   = biq_pkg::COEF_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  biq_pkg::ctl_t                                 ctl,
  output biq_pkg::stat_t                                stat,
  input  logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs,
  input  logic signed [SAMPLE_WIDTH-1:0]                in_sample_in,
  input  logic                                          in_restart,
  input  logic                                          in_block_end,
  output logic signed [SAMPLE_WIDTH-1:0]                out_sample_out,
  output logic                                          out_overflow,
  output logic                                          out_block_end_out,
  output logic                                          out_valid,
  input  logic                                          out_ready
);

  // Grid alignment of products and state within the accumulator
  localparam int unsigned STATE_W  = SAMPLE_WIDTH + 24;
  localparam int unsigned PROD_W   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int unsigned PROD_LSH = (COEF_WIDTH < 24) ? (24 - COEF_WIDTH) : 0;
  localparam int unsigned ST_LSH   = (COEF_WIDTH > 24) ? (COEF_WIDTH - 24) : 0;
  localparam int unsigned ACC_W    = PROD_W + PROD_LSH + 2;
  localparam int unsigned OUT_RSH  = COEF_WIDTH - 2 + PROD_LSH;
  localparam int unsigned ST_RSH   = ST_LSH;

  localparam logic signed [ACC_W-1:0] Y_HALF  = (ACC_W'(1) << OUT_RSH) >> 1;
  localparam logic signed [ACC_W-1:0] ST_HALF = (ACC_W'(1) << ST_RSH) >> 1;
  localparam logic signed [ACC_W-1:0] Y_MAX   =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN   =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ST_MAX  =
    {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ST_MIN  =
    {{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic                           bend_r;
  logic signed [SAMPLE_WIDTH-1:0] y_r;
  logic signed [STATE_W-1:0]      n1_r;
  logic signed [STATE_W-1:0]      d1_r;
  logic signed [STATE_W-1:0]      d2_r;
  logic                           ovf_r;
  logic signed [PROD_W-1:0]       mul_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        acc_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_ovf_r;
  logic                           out_bend_r;
  logic                           out_valid_r;

  logic signed [COEF_WIDTH-1:0]   mul_a;
  logic signed [SAMPLE_WIDTH-1:0] mul_b;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W-1:0]        s1_ext;
  logic signed [ACC_W-1:0]        s2_ext;
  logic signed [ACC_W-1:0]        y_rnd;
  logic signed [ACC_W-1:0]        st_rnd;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic signed [STATE_W-1:0]      st_sat;
  logic                           y_ovf;
  logic                           st_ovf;
  logic                           commit;

  assign commit        = (ctl.sat_dst == biq_pkg::SAT_N2);
  assign stat.out_free = !out_valid_r || out_ready;

  // Multiplier operands: selected coefficient times input or output sample
  assign mul_a = $signed(coefs[ctl.coef_sel]);
  assign mul_b = ctl.mul_y ? y_r : x_r;

  // Align product and state terms to the accumulator grid
  assign prod_ext = ACC_W'(mul_r) <<< PROD_LSH;
  assign s1_ext   = ACC_W'(d1_r) <<< ST_LSH;
  assign s2_ext   = ACC_W'(d2_r) <<< ST_LSH;

  // Round half up, then clamp to the sample range
  assign y_rnd = (acc_r + Y_HALF) >>> OUT_RSH;
  always_comb begin
    y_ovf = 1'b1;
    if (y_rnd > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (y_rnd < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = y_rnd[SAMPLE_WIDTH-1:0];
      y_ovf = 1'b0;
    end
  end

  // Round half up, then clamp to the state range
  assign st_rnd = (acc_r + ST_HALF) >>> ST_RSH;
  always_comb begin
    st_ovf = 1'b1;
    if (st_rnd > ST_MAX) begin
      st_sat = ST_MAX[STATE_W-1:0];
    end else if (st_rnd < ST_MIN) begin
      st_sat = ST_MIN[STATE_W-1:0];
    end else begin
      st_sat = st_rnd[STATE_W-1:0];
      st_ovf = 1'b0;
    end
  end

  // Accumulator next value
  always_comb begin
    unique case (ctl.acc_op)
      biq_pkg::ACC_LD_S1: acc_nxt = s1_ext;
      biq_pkg::ACC_LD_S2: acc_nxt = s2_ext + prod_ext;
      biq_pkg::ACC_LD_P:  acc_nxt = prod_ext;
      biq_pkg::ACC_ADD:   acc_nxt = acc_r + prod_ext;
      biq_pkg::ACC_SUB:   acc_nxt = acc_r - prod_ext;
      default:            acc_nxt = acc_r;
    endcase
  end

  // Arithmetic payload registers
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      x_r    <= in_sample_in;
      bend_r <= in_block_end;
    end
    if (ctl.mul_en) begin
      mul_r <= mul_a * mul_b;
    end
    acc_r <= acc_nxt;
    if (ctl.sat_dst == biq_pkg::SAT_Y) begin
      y_r <= y_sat;
    end
    if (ctl.sat_dst == biq_pkg::SAT_N1) begin
      n1_r <= st_sat;
    end
    if (commit) begin
      out_sample_r <= y_r;
      out_ovf_r    <= ovf_r | st_ovf;
      out_bend_r   <= bend_r;
    end
  end

  // Filter state and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r  <= '0;
      d2_r  <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (ctl.load_in) begin
        ovf_r <= 1'b0;
        if (in_restart) begin
          d1_r <= '0;
          d2_r <= '0;
        end
      end
      if (ctl.sat_dst == biq_pkg::SAT_Y) begin
        ovf_r <= ovf_r | y_ovf;
      end
      if (ctl.sat_dst == biq_pkg::SAT_N1) begin
        ovf_r <= ovf_r | st_ovf;
      end
      if (commit) begin
        d1_r <= n1_r;
        d2_r <= st_sat;
      end
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_sample_out    = out_sample_r;
  assign out_overflow      = out_ovf_r;
  assign out_block_end_out = out_bend_r;
  assign out_valid         = out_valid_r;

`ifndef SYNTH
  // A result is written only into a free output slot
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_ready))
    else $error("result overwrote a pending output word");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load_in && in_restart) |=> (d1_r == '0 && d2_r == '0))
    else $error("restart did not clear the filter state");
`endif

endmodule

// ===== src/biquad_iir_filter.sv =====
// ----------------------------------------------------------------------------
// Biquad IIR filter, transposed direct form II
// Samples are processed one at a time by the nine-step microprogram that
// shares one multiplier; the next input word is taken only after the last
// result is committed, which waits while the output word is held.
// Reset (synchronous, active low): b0 = 1.0, other coefficients zero, both
// filter states zero, output register empty.
// ----------------------------------------------------------------------------
module biquad_iir_filter #(
  parameter int unsigned SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH   = biq_pkg::COEF_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Input channel
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]           in_sample_in,
  input  logic                                     in_restart,
  input  logic                                     in_block_end,
  // Result channel
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]           out_sample_out,
  output logic                                     out_overflow,
  output logic                                     out_block_end_out,
  // Configuration port
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [((COEF_WIDTH > 32) ? 6 : 5)-1:0]   paddr,
  input  logic [((COEF_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COEF_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                                     pready
);

  logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs;
  biq_pkg::ctl_t                                 ctl;
  biq_pkg::stat_t                                stat;

  // Coefficient registers
  biq_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  // Microprogram sequencer
  biq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Arithmetic datapath
  biq_dpath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .stat              (stat),
    .coefs             (coefs),
    .in_sample_in      (in_sample_in),
    .in_restart        (in_restart),
    .in_block_end      (in_block_end),
    .out_sample_out    (out_sample_out),
    .out_overflow      (out_overflow),
    .out_block_end_out (out_block_end_out),
    .out_valid         (out_valid),
    .out_ready         (out_ready)
  );

endmodule

// ===== tb/tb_biquad_iir_filter.sv =====
// ----------------------------------------------------------------------------
// Biquad IIR filter testbench
// Drives sample words through the transposed direct form II section under
// bursty input and a stalling sink and reprograms the five coefficients over
// the register port between phases. Every output word is checked against a
// bit-exact fixed-point model or typed-in word; register readback is checked.
// ----------------------------------------------------------------------------
module tb_biquad_iir_filter;
  import biq_pkg::*;

  localparam int unsigned SW          = SAMPLE_WIDTH_DEF;
  localparam int unsigned CW          = COEF_WIDTH_DEF;
  localparam int unsigned STATE_W     = SW + 24;
  localparam int unsigned OUT_SHIFT   = CW - 2;
  localparam int unsigned STATE_SHIFT = CW - 24;
  localparam longint      STATE_SCALE = longint'(1) <<< STATE_SHIFT;
  localparam int          RANDOM_WORDS = 1350;
  localparam int          CYCLE_LIMIT  = 500000;

  localparam logic [COEF_IDX_W-1:0] COEF_ORDER [NUM_COEFS] =
    '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic                 ovf;
    logic                 bend;
  } out_word_t;

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic                 rst;
    logic                 bend;
    logic                 fixed;   // expected word typed in, not predicted
    out_word_t            want;
  } in_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic signed [SW-1:0]  smp;
    logic                  rst;
    logic                  bend;
    logic                  fixed;
    logic signed [SW-1:0]  y;
    logic                  ovf;
    logic [COEF_IDX_W-1:0] reg_idx;
    logic [CW-1:0]         value;
  } row_t;

  // Directed plan: unity gain after reset, saturation at both coefficient
  // extremes, state saturation, restart and end-of-buffer marks
  localparam row_t PLAN [35] = '{
    '{ROW_WORD, 24'h7FFFFF, 0, 0, 1, 24'h7FFFFF, 0, REG_B0, 32'h0},
    '{ROW_WORD, 24'h800000, 0, 1, 1, 24'h800000, 0, REG_B0, 32'h0},
    '{ROW_WORD, 24'h000000, 0, 0, 1, 24'h000000, 0, REG_B0, 32'h0},
    '{ROW_WORD, 24'h000001, 1, 0, 1, 24'h000001, 0, REG_B0, 32'h0},
    '{ROW_WORD, 24'hFFFFFF, 0, 1, 1, 24'hFFFFFF, 0, REG_B0, 32'h0},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_B0, 32'h7FFFFFFF},
    '{ROW_WORD, 24'h7FFFFF, 1, 0, 1, 24'h7FFFFF, 1, REG_B0, 32'h0},
    '{ROW_WORD, 24'h800000, 0, 0, 1, 24'h800000, 1, REG_B0, 32'h0},
    '{ROW_WORD, 24'h000000, 0, 1, 1, 24'h000000, 0, REG_B0, 32'h0},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_B0, 32'h80000000},
    '{ROW_WORD, 24'h800000, 1, 0, 1, 24'h7FFFFF, 1, REG_B0, 32'h0},
    '{ROW_WORD, 24'h7FFFFF, 0, 0, 1, 24'h800000, 1, REG_B0, 32'h0},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_B1, 32'h80000000},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_B2, 32'h80000000},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_A1, 32'h80000000},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_A2, 32'h80000000},
    '{ROW_WORD, 24'h800000, 1, 0, 0, 24'h0,      0, REG_B0, 32'h0},
    '{ROW_WORD, 24'h800000, 0, 0, 0, 24'h0,      0, REG_B0, 32'h0},
    '{ROW_WORD, 24'h7FFFFF, 0, 1, 0, 24'h0,      0, REG_B0, 32'h0},
    '{ROW_WORD, 24'h000001, 0, 0, 0, 24'h0,      0, REG_B0, 32'h0},
    '{ROW_WORD, 24'h800000, 1, 1, 0, 24'h0,      0, REG_B0, 32'h0},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_B0, 32'h40000000},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_B1, 32'h7FFFFFFF},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_B2, 32'h7FFFFFFF},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_A1, 32'h7FFFFFFF},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_A2, 32'h7FFFFFFF},
    '{ROW_WORD, 24'h7FFFFF, 1, 0, 0, 24'h0,      0, REG_B0, 32'h0},
    '{ROW_WORD, 24'h800000, 0, 0, 0, 24'h0,      0, REG_B0, 32'h0},
    '{ROW_WORD, 24'h123456, 0, 1, 0, 24'h0,      0, REG_B0, 32'h0},
    '{ROW_WORD, 24'h000000, 1, 0, 0, 24'h0,      0, REG_B0, 32'h0},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_B1, 32'h0},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_B2, 32'h0},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_A1, 32'h0},
    '{ROW_REG,  24'h0,      0, 0, 0, 24'h0,      0, REG_A2, 32'h0},
    '{ROW_WORD, 24'hAAAAAA, 0, 1, 0, 24'h0,      0, REG_B0, 32'h0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] in_sample_in = '0;
  logic                 in_restart = 1'b0;
  logic                 in_block_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] out_sample_out;
  logic                 out_overflow;
  logic                 out_block_end_out;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [4:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Filter model state and coefficient copy
  logic signed [CW-1:0] coef_now [NUM_COEFS];
  longint               s_one;
  longint               s_two;

  in_word_t  samples_to_send [$];
  out_word_t words_due [$];
  in_word_t  cur_word;
  bit        word_taken;
  int        burst_left = 1;
  int        gap_left = 0;
  logic [31:0] sink_pat = '1;
  int        sink_left = 0;
  int        cycles = 0;
  int        fails = 0;

  biquad_iir_filter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_in      (in_sample_in),
    .in_restart        (in_restart),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_overflow      (out_overflow),
    .out_block_end_out (out_block_end_out),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #10 clk = ~clk;

  task automatic report_bad(input string what, input longint got, input longint want);
    fails++;
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // Round half up onto a coarser grid
  function automatic longint round_grid(input longint v, input int unsigned sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_width(input longint v, input int unsigned w,
                                         inout bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // One sample through the section: output first, then both delays
  function automatic out_word_t tdf2_step(input in_word_t w);
    longint    x;
    longint    acc;
    longint    y;
    longint    n1;
    longint    n2;
    bit        hit;
    out_word_t r;
    hit = 1'b0;
    x = w.smp;
    if (w.rst) begin
      s_one = 0;
      s_two = 0;
    end
    acc = s_one * STATE_SCALE + longint'(coef_now[REG_B0]) * x;
    y = clamp_width(round_grid(acc, OUT_SHIFT), SW, hit);
    acc = s_two * STATE_SCALE + longint'(coef_now[REG_B1]) * x
          - longint'(coef_now[REG_A1]) * y;
    n1 = clamp_width(round_grid(acc, STATE_SHIFT), STATE_W, hit);
    acc = longint'(coef_now[REG_B2]) * x - longint'(coef_now[REG_A2]) * y;
    n2 = clamp_width(round_grid(acc, STATE_SHIFT), STATE_W, hit);
    s_one = n1;
    s_two = n2;
    r.smp = y[SW-1:0];
    r.ovf = hit;
    r.bend = w.bend;
    return r;
  endfunction

  // Write one coefficient, then read it back in a following transfer
  task automatic program_coef(input logic [COEF_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    coef_now[idx] = val;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== val)
      report_bad("coefficient readback", prdata, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold until no word is queued, offered or still owed by the block
  task automatic wait_idle;
    while (samples_to_send.size() != 0 || in_valid || words_due.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef(input int mode);
    logic [31:0] v;
    v = $urandom;
    if (mode == 1) begin
      case ($urandom_range(0, 6))
        0: v = 32'h7FFFFFFF;
        1: v = 32'h80000000;
        2: v = 32'h00000000;
        3: v = 32'h40000000;
        4: v = 32'hC0000000;
        5: v = 32'h00000001;
        default: v = 32'hFFFFFFFF;
      endcase
    end else if (mode == 2) begin
      v = $urandom_range(0, 32'h20000000) - 32'h10000000;
    end
    return v;
  endfunction

  function automatic logic signed [SW-1:0] pick_sample;
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: r = $urandom_range(0, 1) ? 32'h007FFFFF : 32'h00800000;
      1, 2: r = $urandom_range(0, 1023) - 512;
      default: ;
    endcase
    return r[SW-1:0];
  endfunction

  // Sender: present the next word in bursts separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (samples_to_send.size() != 0) begin
        cur_word = samples_to_send.pop_front();
        in_valid <= 1'b1;
        in_sample_in <= cur_word.smp;
        in_restart <= cur_word.rst;
        in_block_end <= cur_word.bend;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sink: stall on a rotating pattern, reloaded now and then
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_left = $urandom_range(50, 400);
      sink_pat = ($urandom_range(0, 3) == 0) ? 32'hFFFFFFFF : ($urandom | 32'h1);
    end
    sink_left--;
    out_ready <= sink_pat[0];
    sink_pat = {sink_pat[0], sink_pat[31:1]};
  end

  // Check output words and predict each accepted input word
  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    cycles++;
    word_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (words_due.size() == 0) begin
          report_bad("output word with none due", out_sample_out, 0);
        end else begin
          want = words_due.pop_front();
          if (out_sample_out !== want.smp)
            report_bad("sample_out", out_sample_out, want.smp);
          if (out_overflow !== want.ovf)
            report_bad("overflow", out_overflow, want.ovf);
          if (out_block_end_out !== want.bend)
            report_bad("block_end_out", out_block_end_out, want.bend);
        end
      end
      word_taken = in_valid && in_ready;
      if (word_taken) begin
        got = tdf2_step(cur_word);
        words_due.push_back(cur_word.fixed ? cur_word.want : got);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int       sent;
    int       mode;
    int       n;
    int       blen;
    coef_now[REG_B0] = 32'h40000000;
    coef_now[REG_B1] = '0;
    coef_now[REG_B2] = '0;
    coef_now[REG_A1] = '0;
    coef_now[REG_A2] = '0;
    s_one = 0;
    s_two = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed plan; register rows wait for the block to drain
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_REG) begin
        wait_idle();
        program_coef(PLAN[i].reg_idx, PLAN[i].value);
      end else begin
        w.smp = PLAN[i].smp;
        w.rst = PLAN[i].rst;
        w.bend = PLAN[i].bend;
        w.fixed = PLAN[i].fixed;
        w.want.smp = PLAN[i].y;
        w.want.ovf = PLAN[i].ovf;
        w.want.bend = PLAN[i].bend;
        samples_to_send.push_back(w);
      end
    end

    // Random phases: fresh coefficients, then a stream of buffers
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wait_idle();
      mode = $urandom_range(0, 2);
      foreach (COEF_ORDER[r])
        program_coef(COEF_ORDER[r], pick_coef(mode));
      n = $urandom_range(20, 90);
      if (n > RANDOM_WORDS - sent)
        n = RANDOM_WORDS - sent;
      blen = $urandom_range(4, 48);
      for (int k = 0; k < n; k++) begin
        w.smp = pick_sample();
        w.rst = (k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 60) == 0;
        w.bend = (k % blen == blen - 1) || $urandom_range(0, 40) == 0;
        w.fixed = 1'b0;
        w.want = '0;
        samples_to_send.push_back(w);
      end
      sent += n;
    end

    wait_idle();
    repeat (30) @(posedge clk);
    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
